/* design/pli_pkg.sv */
// Shared types and constants for the positional list block.
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

  localparam int CAPACITY_DEFAULT = 32;
  localparam int POS_W = 6;
  localparam int ELEM_W = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W = 6;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [POS_W-1:0] slot;
  } pli_ctl_t;

endpackage

`default_nettype wire

/* design/pli_cell.sv */
// One list slot: holds an element and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module pli_cell #(
  parameter int CAPACITY = pli_pkg::CAPACITY_DEFAULT,
  parameter int IDX = 0
) (
  input  wire logic                       clk,
  input  wire pli_pkg::pli_ctl_t          ctl,
  input  wire logic [pli_pkg::ELEM_W-1:0] ins_value,
  input  wire logic [pli_pkg::ELEM_W-1:0] left_data,
  input  wire logic [pli_pkg::ELEM_W-1:0] right_data,
  output logic      [pli_pkg::ELEM_W-1:0] data,
  output logic      [pli_pkg::ELEM_W-1:0] sel_data
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = (IW > pli_pkg::POS_W) ? IW : pli_pkg::POS_W;
  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

  logic [CMP_W-1:0] slot;
  logic             at_slot;
  logic             past_slot;

  assign slot = CMP_W'(ctl.slot);
  assign at_slot = (slot == MY_IDX);
  assign past_slot = (MY_IDX > slot);

  // Zero unless this cell sits at the addressed slot.
  assign sel_data = at_slot ? data : '0;

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (at_slot) begin
        data <= ins_value;
      end else if (past_slot) begin
        data <= left_data;
      end
    end else if (ctl.del) begin
      if (at_slot || past_slot) begin
        data <= right_data;
      end
    end
  end

endmodule

`default_nettype wire

/* design/positional_list_insert_delete.sv */
// Top level of the positional list: count, status logic and the cell chain.
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit elements, edited by insert and
// delete at a 1-based position. Each slot is a cell that loads, holds or takes
// its neighbor's element, so every operation completes in the cycle it is
// accepted, and its result is then held in an output register. One item is
// taken per cycle; the result register is the only limit, and it frees in the
// same cycle its item is taken. Status is 0 ok, 1 bad position, 2 full; a bad
// position wins over full. length carries the low six bits of the element
// count.
module positional_list_insert_delete #(
  parameter int CAPACITY = pli_pkg::CAPACITY_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         op,
  input  wire logic [pli_pkg::POS_W-1:0]    position,
  input  wire logic [pli_pkg::ELEM_W-1:0]   value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [pli_pkg::STATUS_W-1:0] status,
  output logic      [pli_pkg::ELEM_W-1:0]   removed_value,
  output logic      [pli_pkg::LEN_W-1:0]    length
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EW = ((CNT_W > pli_pkg::POS_W) ? CNT_W : pli_pkg::POS_W) + 1;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             in_acc;
  logic [EW-1:0]    pos_ext;
  logic [EW-1:0]    cnt_ext;
  logic             pos_zero;
  logic             ins_badpos;
  logic             del_badpos;
  logic             is_full;
  logic             ins_ok;
  logic             del_ok;
  pli_pkg::status_t status_next;
  pli_pkg::pli_ctl_t ctl;

  logic [pli_pkg::ELEM_W-1:0] cell_data [CAPACITY];
  logic [pli_pkg::ELEM_W-1:0] cell_sel  [CAPACITY];
  logic [pli_pkg::ELEM_W-1:0] removed_next;

  assign in_stall = out_valid && out_stall;
  assign in_acc = in_valid && !in_stall;

  assign pos_ext = EW'(position);
  assign cnt_ext = EW'(count);
  assign pos_zero = (position == '0);
  assign ins_badpos = pos_zero || (pos_ext > cnt_ext + EW'(1));
  assign del_badpos = pos_zero || (pos_ext > cnt_ext);
  assign is_full = (count == FULL_COUNT);
  assign ins_ok = (op == 1'b0) && !ins_badpos && !is_full;
  assign del_ok = (op == 1'b1) && !del_badpos;

  assign ctl.ins = in_acc && ins_ok;
  assign ctl.del = in_acc && del_ok;
  assign ctl.slot = position - pli_pkg::POS_W'(1);

  always_comb begin
    if (op == 1'b0) begin
      if (ins_badpos) begin
        status_next = pli_pkg::ST_BADPOS;
      end else if (is_full) begin
        status_next = pli_pkg::ST_FULL;
      end else begin
        status_next = pli_pkg::ST_OK;
      end
    end else begin
      status_next = del_badpos ? pli_pkg::ST_BADPOS : pli_pkg::ST_OK;
    end
  end

  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.del) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Only the addressed cell drives a nonzero value; merge them.
  always_comb begin
    removed_next = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed_next = removed_next | cell_sel[i];
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [pli_pkg::ELEM_W-1:0] left_data;
    logic [pli_pkg::ELEM_W-1:0] right_data;

    if (g == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_mid_l
      assign left_data = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[g];
    end else begin : g_mid_r
      assign right_data = cell_data[g+1];
    end

    pli_cell #(
      .CAPACITY(CAPACITY),
      .IDX(g)
    ) u_cell (
      .clk(clk),
      .ctl(ctl),
      .ins_value(value),
      .left_data(left_data),
      .right_data(right_data),
      .data(cell_data[g]),
      .sel_data(cell_sel[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (in_acc) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status <= status_next;
      removed_value <= ctl.del ? removed_next : '0;
      length <= pli_pkg::LEN_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("element count above capacity");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_fail_no_change: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !ctl.ins && !ctl.del) |=> ($stable(count) &&
      status != pli_pkg::ST_OK && removed_value == '0))
    else $error("failed item changed the list or reported ok");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (in_acc && op == 1'b0 && is_full && !ins_badpos) |=>
      status == pli_pkg::ST_FULL)
    else $error("insert into full list not flagged");

endmodule

`default_nettype wire

/* bench/positional_list_insert_delete_test.sv */
// Self-checking testbench for the positional list: random edits against a list predictor.
`timescale 1ns / 1ps

module positional_list_insert_delete_test;

  localparam int LIST_CAP = pli_pkg::CAPACITY_DEFAULT;
  localparam int RANDOM_ITEMS = 1280;
  localparam int STALL_LIMIT = 4000;
  localparam int SHOWN_ERRORS = 10;
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef struct {
    logic                       op;
    logic [pli_pkg::POS_W-1:0]  pos;
    logic [pli_pkg::ELEM_W-1:0] val;
    bit                         drain_first;
  } list_cmd_t;

  typedef struct {
    pli_pkg::status_t           status;
    logic [pli_pkg::ELEM_W-1:0] removed;
    logic [pli_pkg::LEN_W-1:0]  len;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = OP_INSERT;
  logic [pli_pkg::POS_W-1:0] position = '0;
  logic [pli_pkg::ELEM_W-1:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [pli_pkg::STATUS_W-1:0] status;
  logic [pli_pkg::ELEM_W-1:0] removed_value;
  logic [pli_pkg::LEN_W-1:0] length;

  list_cmd_t cmd_queue[$];
  list_result_t result_queue[$];
  list_cmd_t cmd_on_bus;
  int total_items = 0;
  int n_issued = 0;
  int n_checked = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int gen_len = 0;

  // predicted contents of the list
  logic [pli_pkg::ELEM_W-1:0] list_mem [0:LIST_CAP-1];
  int list_count = 0;

  positional_list_insert_delete #(.CAPACITY(LIST_CAP)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .position(position),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .removed_value(removed_value),
    .length(length)
  );

  always #1 clk = ~clk;

  task automatic apply_list_edit(input list_cmd_t c, output list_result_t r);
    int p = int'(c.pos);
    int k;
    r.status = pli_pkg::ST_OK;
    r.removed = '0;
    if (c.op == OP_INSERT) begin
      if (p == 0 || p > list_count + 1) begin
        r.status = pli_pkg::ST_BADPOS;
      end else if (list_count >= LIST_CAP) begin
        r.status = pli_pkg::ST_FULL;
      end else begin
        for (k = list_count; k > p - 1; k--) list_mem[k] = list_mem[k-1];
        list_mem[p-1] = c.val;
        list_count++;
      end
    end else begin
      if (p == 0 || p > list_count) begin
        r.status = pli_pkg::ST_BADPOS;
      end else begin
        r.removed = list_mem[p-1];
        for (k = p - 1; k + 1 < list_count; k++) list_mem[k] = list_mem[k+1];
        list_count--;
      end
    end
    r.len = list_count[pli_pkg::LEN_W-1:0];
  endtask

  // Track only the length so the generator can aim at valid positions.
  task automatic queue_edit(input logic o, input int p,
                            input logic [pli_pkg::ELEM_W-1:0] v, input bit hold);
    list_cmd_t c;
    c.op = o;
    c.pos = p[pli_pkg::POS_W-1:0];
    c.val = v;
    c.drain_first = hold;
    cmd_queue.push_back(c);
    if (o == OP_INSERT) begin
      if (p >= 1 && p <= gen_len + 1 && gen_len < LIST_CAP) gen_len++;
    end else if (p >= 1 && p <= gen_len) begin
      gen_len--;
    end
  endtask

  function automatic logic [pli_pkg::ELEM_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int idle_phase(int issued);
    int ph = (total_items == 0) ? 0 : issued * 3 / total_items;
    return (ph > 2) ? 2 : ph;
  endfunction

  function automatic int sender_idle_pct(int ph);
    return (ph == 0) ? 8 : (ph == 1) ? 88 : 0;
  endfunction

  function automatic int receiver_stall_pct(int ph);
    return (ph == 0) ? 88 : (ph == 1) ? 8 : 0;
  endfunction

  // Driver: hold a stalled item, otherwise load the next one or idle.
  always @(posedge clk) begin
    list_result_t r;
    int issued;
    bit load;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      issued = n_issued;
      if (in_valid && !in_stall) begin
        apply_list_edit(cmd_on_bus, r);
        result_queue.push_back(r);
        issued++;
      end
      if (!(in_valid && in_stall)) begin
        load = cmd_queue.size() > 0 &&
               $urandom_range(99) >= sender_idle_pct(idle_phase(issued));
        if (load && cmd_queue[0].drain_first && issued != n_checked) load = 1'b0;
        if (load) begin
          cmd_on_bus = cmd_queue.pop_front();
          in_valid <= 1'b1;
          op <= cmd_on_bus.op;
          position <= cmd_on_bus.pos;
          value <= cmd_on_bus.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
      n_issued <= issued;
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    list_result_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS)
            $display("ERROR: result with no item pending: status %0d removed %h length %0d",
                     status, removed_value, length);
        end else begin
          e = result_queue.pop_front();
          if (status !== e.status || removed_value !== e.removed || length !== e.len) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
              $display("ERROR: result %0d: status %0d/%0d removed %h/%h length %0d/%0d",
                       n_checked, e.status, status, e.removed, removed_value,
                       e.len, length);
          end
        end
        n_checked <= n_checked + 1;
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct(idle_phase(n_issued)));
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    bit fill;
    logic o;
    int p;
    int lim;
    int i;

    // directed: bad positions, ends, middle, empty list
    queue_edit(OP_DELETE, 1, '0, 0);
    queue_edit(OP_INSERT, 0, 32'h1111_1111, 0);
    queue_edit(OP_DELETE, 0, '0, 0);
    queue_edit(OP_INSERT, 2, 32'h2222_2222, 0);
    queue_edit(OP_INSERT, 1, 32'h8000_0000, 0);
    queue_edit(OP_INSERT, 2, 32'h7FFF_FFFF, 0);
    queue_edit(OP_INSERT, 1, 32'hFFFF_FFFF, 0);
    queue_edit(OP_INSERT, 2, 32'h0000_0000, 0);
    queue_edit(OP_INSERT, 63, 32'hDEAD_BEEF, 0);
    queue_edit(OP_INSERT, 6, 32'hCAFE_F00D, 0);
    queue_edit(OP_INSERT, 5, 32'h1234_5678, 0);
    queue_edit(OP_DELETE, 6, 32'hFFFF_FFFF, 0);
    queue_edit(OP_DELETE, 63, '0, 0);
    queue_edit(OP_DELETE, 3, '0, 0);
    queue_edit(OP_DELETE, 4, '0, 0);
    queue_edit(OP_DELETE, 1, '0, 0);
    queue_edit(OP_DELETE, 0, '0, 0);
    queue_edit(OP_INSERT, 1, 32'h5A5A_5A5A, 0);
    queue_edit(OP_DELETE, 2, '0, 0);
    queue_edit(OP_DELETE, 1, '0, 0);
    queue_edit(OP_DELETE, 1, '0, 0);
    queue_edit(OP_INSERT, 33, 32'hA5A5_A5A5, 0);

    // random: sweep the list between empty and full, hitting full inserts
    fill = 1'b1;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (fill && gen_len == LIST_CAP && $urandom_range(3) == 0) fill = 1'b0;
      else if (!fill && gen_len == 0) fill = 1'b1;
      else if ($urandom_range(39) == 0) fill = !fill;
      if ($urandom_range(99) < 10) begin
        o = 1'($urandom_range(1));
        p = int'($urandom_range(63));
      end else begin
        if ($urandom_range(99) < 80) o = fill ? OP_INSERT : OP_DELETE;
        else o = fill ? OP_DELETE : OP_INSERT;
        lim = (o == OP_INSERT) ? gen_len + 1 : gen_len;
        p = (lim == 0) ? 1 : int'($urandom_range(lim, 1));
      end
      queue_edit(o, p, pick_value(),
                 i == RANDOM_ITEMS / 3 || i == 2 * RANDOM_ITEMS / 3 ||
                 $urandom_range(199) == 0);
    end
    total_items = cmd_queue.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (!(n_issued == total_items && n_checked == total_items)) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && result_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
design/pli_pkg.sv
design/pli_cell.sv
design/positional_list_insert_delete.sv
bench/positional_list_insert_delete_test.sv
